>>> rtl/gmd_pkg.sv
// shared types and constants for the grid maze depth-first path block
// no dependencies
package gmd_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int POS_W    = 2 * COORD_W;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int DEPTH_W  = POS_W + 1;
  localparam int SIDE_W   = COORD_W + 1;

  localparam logic [1:0] KIND_WALL  = 2'd0;
  localparam logic [1:0] KIND_OPEN  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic RES_REPORT = 1'b0;
  localparam logic RES_STEP   = 1'b1;

  localparam logic [2:0] DIR_RIGHT = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t       pos;
    logic [2:0] dir;
  } stack_entry_t;

  typedef struct packed {
    pos_t       addr;
    logic       grid_we;
    logic [1:0] kind;
    logic       vis_we;
    logic       vis;
  } cell_req_t;

  typedef struct packed {
    logic [POS_W-1:0] addr;
    logic             we;
    stack_entry_t     wdata;
  } stack_req_t;

endpackage

>>> rtl/gmd_if.sv
// channel interfaces for input items, results and the configuration write
// depends on gmd_pkg
interface gmd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] row;
  logic [5:0] col;
  logic [1:0] cell_kind;
  modport source(output valid, operation, row, col, cell_kind, input ready);
  modport sink(input valid, operation, row, col, cell_kind, output ready);
endinterface

interface gmd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic                      path_found;
  logic [gmd_pkg::DEPTH_W-1:0] path_length;
  logic [5:0]                step_row;
  logic [5:0]                step_col;
  logic                      step_last;
  modport source(output valid, result_kind, path_found, path_length, step_row, step_col,
                 step_last, input ready);
  modport sink(input valid, result_kind, path_found, path_length, step_row, step_col,
               step_last, output ready);
endinterface

interface gmd_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] grid_size;
  modport source(output valid, grid_size, input ready);
  modport sink(input valid, grid_size, output ready);
endinterface

>>> rtl/gmd_cell_mem.sv
// cell kind and visited mark memories, one shared address per cycle
// depends on gmd_pkg
module gmd_cell_mem (
  input  logic               clk,
  input  gmd_pkg::cell_req_t req,
  output logic [1:0]         kind_rd,
  output logic               vis_rd
);

  logic [1:0] grid_mem [gmd_pkg::CELLS];
  logic       vis_mem  [gmd_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.grid_we) begin
      grid_mem[req.addr] <= req.kind;
    end
    if (req.vis_we) begin
      vis_mem[req.addr] <= req.vis;
    end
    kind_rd <= grid_mem[req.addr];
    vis_rd  <= vis_mem[req.addr];
  end

endmodule

>>> rtl/gmd_stack_mem.sv
// search stack memory, entries below the top of stack
// depends on gmd_pkg
module gmd_stack_mem (
  input  logic                  clk,
  input  gmd_pkg::stack_req_t   req,
  output gmd_pkg::stack_entry_t rdata
);

  gmd_pkg::stack_entry_t mem [gmd_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

>>> rtl/grid_maze_dfs_path.sv
// top level of the grid maze depth-first path block: sequencer and output register
// depends on gmd_pkg, gmd_if, gmd_cell_mem, gmd_stack_mem
//
// a load transfer writes one cell. a search clears the visited map in a pass
// over the cell memory, then walks depth-first from the last loaded start cell
// trying right, down, left, up; each neighbor try is a bounds check, then, if
// in bounds, a registered read of the cell and visited memories; a backtrack
// reads the stack memory. a search returns one report transfer. a read transfer
// returns the next path cell, start first, if a path was found and cells remain.
// the top of stack is held in registers, the rest of the path in the stack
// memory. input is taken only while no search or read is in progress.
module grid_maze_dfs_path (
  input  logic clk,
  input  logic rst_n,
  gmd_in_if.sink    in_ch,
  gmd_out_if.source out_ch,
  gmd_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_POPW  = 3'd5;
  localparam logic [2:0] ST_RPT   = 3'd6;
  localparam logic [2:0] ST_RD    = 3'd7;

  localparam int CW = gmd_pkg::COORD_W;
  localparam int DW = gmd_pkg::DEPTH_W;
  localparam int SW = gmd_pkg::SIDE_W;

  logic [2:0]    state_r, state_nxt;
  logic [6:0]    grid_size_r;
  gmd_pkg::pos_t start_r, start_nxt;
  gmd_pkg::pos_t clr_r, clr_nxt;
  gmd_pkg::pos_t top_pos_r, top_pos_nxt;
  logic [2:0]    dir_r, dir_nxt;
  gmd_pkg::pos_t npos_r, npos_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] rp_r, rp_nxt;
  logic          found_r, found_nxt;

  // output register
  logic          ov_r, ov_nxt;
  logic          o_kind_r, o_kind_nxt;
  logic          o_found_r, o_found_nxt;
  logic [DW-1:0] o_len_r, o_len_nxt;
  logic [CW-1:0] o_row_r, o_row_nxt, o_col_r, o_col_nxt;
  logic          o_last_r, o_last_nxt;

  gmd_pkg::cell_req_t    cell_req;
  gmd_pkg::stack_req_t   stk_req;
  logic [1:0]            kind_rd;
  logic                  vis_rd;
  gmd_pkg::stack_entry_t stk_rd;

  logic [SW-1:0] side;
  logic          out_free;
  logic          in_xfer;
  logic [CW-1:0] t_row, t_col;
  logic          nb_ok;
  gmd_pkg::pos_t nb_pos;
  logic [SW-1:0] row_ext, col_ext;

  gmd_cell_mem u_cell (.clk(clk), .req(cell_req), .kind_rd(kind_rd), .vis_rd(vis_rd));
  gmd_stack_mem u_stack (.clk(clk), .req(stk_req), .rdata(stk_rd));

  // side in use: zero acts as one, large values clip to the store side
  always_comb begin
    if (grid_size_r == 7'd0) begin
      side = SW'(1);
    end else if (grid_size_r > 7'(gmd_pkg::MAX_SIDE)) begin
      side = SW'(gmd_pkg::MAX_SIDE);
    end else begin
      side = SW'(grid_size_r);
    end
  end

  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // neighbor of the top of stack in the current direction
  assign t_row   = top_pos_r[gmd_pkg::POS_W-1:CW];
  assign t_col   = top_pos_r[CW-1:0];
  assign row_ext = {1'b0, t_row};
  assign col_ext = {1'b0, t_col};
  always_comb begin
    nb_ok  = 1'b0;
    nb_pos = top_pos_r;
    case (dir_r)
      gmd_pkg::DIR_RIGHT: begin
        nb_ok  = (col_ext + SW'(1)) < side;
        nb_pos = {t_row, t_col + CW'(1)};
      end
      gmd_pkg::DIR_DOWN: begin
        nb_ok  = (row_ext + SW'(1)) < side;
        nb_pos = {t_row + CW'(1), t_col};
      end
      gmd_pkg::DIR_LEFT: begin
        nb_ok  = t_col != '0;
        nb_pos = {t_row, t_col - CW'(1)};
      end
      gmd_pkg::DIR_UP: begin
        nb_ok  = t_row != '0;
        nb_pos = {t_row - CW'(1), t_col};
      end
      default: begin
        nb_ok  = 1'b0;
        nb_pos = top_pos_r;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    start_nxt   = start_r;
    clr_nxt     = clr_r;
    top_pos_nxt = top_pos_r;
    dir_nxt     = dir_r;
    npos_nxt    = npos_r;
    depth_nxt   = depth_r;
    rp_nxt      = rp_r;
    found_nxt   = found_r;

    ov_nxt      = ov_r && !out_ch.ready;
    o_kind_nxt  = o_kind_r;
    o_found_nxt = o_found_r;
    o_len_nxt   = o_len_r;
    o_row_nxt   = o_row_r;
    o_col_nxt   = o_col_r;
    o_last_nxt  = o_last_r;

    cell_req      = '0;
    cell_req.addr = npos_r;
    stk_req       = '0;
    stk_req.addr  = rp_r[gmd_pkg::POS_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.operation)
            gmd_pkg::OP_LOAD: begin
              cell_req.addr    = {in_ch.row, in_ch.col};
              cell_req.grid_we = 1'b1;
              cell_req.kind    = in_ch.cell_kind;
              if (in_ch.cell_kind == gmd_pkg::KIND_START) begin
                start_nxt = {in_ch.row, in_ch.col};
              end
            end
            gmd_pkg::OP_SEARCH: begin
              clr_nxt   = '0;
              depth_nxt = '0;
              found_nxt = 1'b0;
              rp_nxt    = '0;
              state_nxt = ST_CLEAR;
            end
            gmd_pkg::OP_READ: begin
              if (found_r && rp_r < depth_r) begin
                state_nxt = ST_RD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // visited map clearing pass, one entry a cycle
      ST_CLEAR: begin
        cell_req.addr   = clr_r;
        cell_req.vis_we = 1'b1;
        cell_req.vis    = 1'b0;
        clr_nxt         = clr_r + gmd_pkg::POS_W'(1);
        if (clr_r == gmd_pkg::POS_W'(gmd_pkg::CELLS - 1)) begin
          state_nxt = ST_INIT;
        end
      end

      ST_INIT: begin
        if ({1'b0, start_r[gmd_pkg::POS_W-1:CW]} >= side ||
            {1'b0, start_r[CW-1:0]} >= side) begin
          state_nxt = ST_RPT;
        end else begin
          cell_req.addr   = start_r;
          cell_req.vis_we = 1'b1;
          cell_req.vis    = 1'b1;
          top_pos_nxt     = start_r;
          dir_nxt         = gmd_pkg::DIR_RIGHT;
          depth_nxt       = DW'(1);
          state_nxt       = ST_STEP;
        end
      end

      ST_STEP: begin
        if (dir_r == gmd_pkg::DIR_DONE) begin
          // backtrack: drop the top, fetch the entry below it
          depth_nxt    = depth_r - DW'(1);
          stk_req.addr = gmd_pkg::POS_W'(depth_r - DW'(2));
          if (depth_r == DW'(1)) begin
            state_nxt = ST_RPT;
          end else begin
            state_nxt = ST_POPW;
          end
        end else begin
          dir_nxt = dir_r + 3'd1;
          if (nb_ok) begin
            cell_req.addr = nb_pos;
            npos_nxt      = nb_pos;
            state_nxt     = ST_CHK;
          end
        end
      end

      ST_CHK: begin
        state_nxt = ST_STEP;
        if (kind_rd != gmd_pkg::KIND_WALL && !vis_rd) begin
          // push: current top goes to memory with its next direction
          stk_req.addr      = gmd_pkg::POS_W'(depth_r - DW'(1));
          stk_req.we        = 1'b1;
          stk_req.wdata.pos = top_pos_r;
          stk_req.wdata.dir = dir_r;
          top_pos_nxt       = npos_r;
          dir_nxt           = gmd_pkg::DIR_RIGHT;
          depth_nxt         = depth_r + DW'(1);
          if (kind_rd == gmd_pkg::KIND_END) begin
            found_nxt = 1'b1;
            state_nxt = ST_RPT;
          end else begin
            cell_req.addr   = npos_r;
            cell_req.vis_we = 1'b1;
            cell_req.vis    = 1'b1;
          end
        end
      end

      ST_POPW: begin
        top_pos_nxt = stk_rd.pos;
        dir_nxt     = stk_rd.dir;
        state_nxt   = ST_STEP;
      end

      ST_RPT: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = gmd_pkg::RES_REPORT;
          o_found_nxt = found_r;
          o_len_nxt   = found_r ? depth_r : '0;
          o_row_nxt   = '0;
          o_col_nxt   = '0;
          o_last_nxt  = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      // path step: last entry lives in the top registers
      ST_RD: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = gmd_pkg::RES_STEP;
          o_found_nxt = 1'b1;
          o_len_nxt   = depth_r;
          o_last_nxt  = (rp_r + DW'(1)) == depth_r;
          if ((rp_r + DW'(1)) == depth_r) begin
            o_row_nxt = top_pos_r[gmd_pkg::POS_W-1:CW];
            o_col_nxt = top_pos_r[CW-1:0];
          end else begin
            o_row_nxt = stk_rd.pos[gmd_pkg::POS_W-1:CW];
            o_col_nxt = stk_rd.pos[CW-1:0];
          end
          rp_nxt    = rp_r + DW'(1);
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_size_r <= 7'(gmd_pkg::MAX_SIDE);
      start_r     <= '0;
      depth_r     <= '0;
      rp_r        <= '0;
      found_r     <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        grid_size_r <= cfg_ch.grid_size;
      end
      start_r <= start_nxt;
      depth_r <= depth_nxt;
      rp_r    <= rp_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_r     <= clr_nxt;
    top_pos_r <= top_pos_nxt;
    dir_r     <= dir_nxt;
    npos_r    <= npos_nxt;
    o_kind_r  <= o_kind_nxt;
    o_found_r <= o_found_nxt;
    o_len_r   <= o_len_nxt;
    o_row_r   <= o_row_nxt;
    o_col_r   <= o_col_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.result_kind = o_kind_r;
  assign out_ch.path_found  = o_found_r;
  assign out_ch.path_length = o_len_r;
  assign out_ch.step_row    = o_row_r;
  assign out_ch.step_col    = o_col_r;
  assign out_ch.step_last   = o_last_r;

endmodule
